### src/gcbe_pkg.sv
// Shared types, codes and constants of the glyph cache budget eviction block.
// Used by every module of the block; depends on nothing else.
package gcbe_pkg;

   localparam int TABLE_DEPTH_DEF = 32;
   localparam logic [31:0] BUDGET_RESET = 32'd524288;
   localparam int COUNT_W = 6;

   localparam logic [2:0] OP_PARK    = 3'd0;
   localparam logic [2:0] OP_RECLAIM = 3'd1;
   localparam logic [2:0] OP_TRIM    = 3'd2;
   localparam logic [2:0] OP_CLEAR   = 3'd3;

   localparam logic [2:0] STAT_DONE  = 3'd0;
   localparam logic [2:0] STAT_HIT   = 3'd1;
   localparam logic [2:0] STAT_MISS  = 3'd2;
   localparam logic [2:0] STAT_FULL  = 3'd3;
   localparam logic [2:0] STAT_EVICT = 3'd4;

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] key;
      logic [23:0] entry_bytes;
      logic [31:0] frame_now;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [31:0]        evicted_key;
      logic               last;
      logic [COUNT_W-1:0] cached_count;
      logic [31:0]        total_bytes;
   } rsp_type;

   typedef struct packed {
      logic [31:0] key;
      logic [31:0] frame;
      logic [23:0] bytes;
   } slot_entry_type;

   typedef struct packed {
      logic [31:0] key;
      logic [31:0] now;
      logic [31:0] best_age;
   } cmp_arg_type;

   typedef struct packed {
      logic        key_eq;
      logic        older;
      logic [31:0] age;
   } cmp_res_type;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_DECIDE,
      SEQ_SWEEP,
      SEQ_EV_READ,
      SEQ_EV_SEND,
      SEQ_FINAL
   } seq_state_type;

endpackage

### src/glyph_cache_budget_eviction.sv
// Top level of the size-budgeted glyph cache eviction table.
// Instantiates gcbe_seq, gcbe_slot_ram and gcbe_cmp_unit; uses gcbe_pkg.
//
//   channel   ports                         transfer
//   request   start, busy, req_payload      start high while busy low
//   result    rsp_strobe, rsp_payload       one-cycle strobe per result, no stall
//   config    csr_we, csr_wdata             csr_we high, byte budget
//
// Park and reclaim make one pass over the slot memory through its single read
// port before the result. Trim makes one such pass per evicted entry; clear
// and zero-budget trim sweep the valid bits instead. Each evicted key is then
// read back from the slot memory and sent as its own result.
// Queries, other codes and within-budget trim go straight to the final state.
// Reset clears all valid bits, the byte total and the budget to 512 KiB at once.
// Results cannot be held off; the block is busy until the last one is sent.
module glyph_cache_budget_eviction #(
   parameter int TABLE_DEPTH = gcbe_pkg::TABLE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  gcbe_pkg::req_type  req_payload,
   output logic               rsp_strobe,
   output gcbe_pkg::rsp_type  rsp_payload,
   input  logic               csr_we,
   input  logic [31:0]        csr_wdata
);
   import gcbe_pkg::*;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   logic           ram_wr_en;
   logic [IDX_W-1:0] ram_wr_addr;
   slot_entry_type ram_wr_data;
   logic [IDX_W-1:0] ram_rd_addr;
   slot_entry_type ram_rd_data;
   cmp_arg_type    cmp_arg;
   cmp_res_type    cmp_res;

   gcbe_seq #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_payload(req_payload),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_strobe (rsp_strobe),
      .rsp_payload(rsp_payload),
      .ram_wr_en  (ram_wr_en),
      .ram_wr_addr(ram_wr_addr),
      .ram_wr_data(ram_wr_data),
      .ram_rd_addr(ram_rd_addr),
      .ram_rd_data(ram_rd_data),
      .cmp_arg    (cmp_arg),
      .cmp_res    (cmp_res)
   );

   gcbe_slot_ram #(
      .TABLE_DEPTH(TABLE_DEPTH)
   ) u_slot_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   gcbe_cmp_unit u_cmp_unit (
      .arg  (cmp_arg),
      .entry(ram_rd_data),
      .res  (cmp_res)
   );

endmodule

### src/gcbe_slot_ram.sv
// Slot memory holding key, frame stamp and byte size of each table entry.
// One write port and one registered read port; uses gcbe_pkg.
module gcbe_slot_ram #(
   parameter int TABLE_DEPTH = gcbe_pkg::TABLE_DEPTH_DEF,
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [IDX_W-1:0]              wr_addr,
   input  gcbe_pkg::slot_entry_type      wr_data,
   input  logic [IDX_W-1:0]              rd_addr,
   output gcbe_pkg::slot_entry_type      rd_data
);
   import gcbe_pkg::*;

   slot_entry_type slot_mem [TABLE_DEPTH];
   slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= slot_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/gcbe_cmp_unit.sv
// Shared compare unit: key match and frame age comparison for one slot entry.
// Used by every scan of the slot memory in the sequencer; uses gcbe_pkg.
module gcbe_cmp_unit (
   input  gcbe_pkg::cmp_arg_type    arg,
   input  gcbe_pkg::slot_entry_type entry,
   output gcbe_pkg::cmp_res_type    res
);
   import gcbe_pkg::*;

   logic [31:0] age;

   assign age        = arg.now - entry.frame;
   assign res.age    = age;
   assign res.older  = age > arg.best_age;
   assign res.key_eq = entry.key == arg.key;

endmodule

### src/gcbe_seq.sv
// Sequencer of the glyph cache: valid bits, byte total, eviction list and
// the scan, sweep, decide and report steps; drives gcbe_slot_ram and gcbe_cmp_unit.
module gcbe_seq #(
   parameter int TABLE_DEPTH = gcbe_pkg::TABLE_DEPTH_DEF,
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  gcbe_pkg::req_type        req_payload,
   input  logic                     csr_we,
   input  logic [31:0]              csr_wdata,
   output logic                     rsp_strobe,
   output gcbe_pkg::rsp_type        rsp_payload,
   output logic                     ram_wr_en,
   output logic [IDX_W-1:0]         ram_wr_addr,
   output gcbe_pkg::slot_entry_type ram_wr_data,
   output logic [IDX_W-1:0]         ram_rd_addr,
   input  gcbe_pkg::slot_entry_type ram_rd_data,
   output gcbe_pkg::cmp_arg_type    cmp_arg,
   input  gcbe_pkg::cmp_res_type    cmp_res
);
   import gcbe_pkg::*;

   localparam int SCAN_W = IDX_W + 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [SCAN_W-1:0] SCAN_END = SCAN_W'(TABLE_DEPTH);

   seq_state_type          state_ff, state_in;
   req_type                req_ff, req_in;
   logic [31:0]            budget_ff, budget_in;
   logic [TABLE_DEPTH-1:0] valid_ff, valid_in;
   logic [31:0]            total_ff, total_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [SCAN_W-1:0]      scan_ff, scan_in;
   logic                   rd_live_ff, rd_live_in;
   logic [IDX_W-1:0]       rd_idx_ff, rd_idx_in;
   logic                   found_ff, found_in;
   logic [IDX_W-1:0]       found_idx_ff, found_idx_in;
   logic [23:0]            found_bytes_ff, found_bytes_in;
   logic [31:0]            best_age_ff, best_age_in;
   logic                   free_found_ff, free_found_in;
   logic [IDX_W-1:0]       free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]       list_ff [TABLE_DEPTH];
   logic [IDX_W-1:0]       list_in [TABLE_DEPTH];
   logic [CNT_W-1:0]       nev_ff, nev_in;
   logic [CNT_W-1:0]       emit_ff, emit_in;
   logic [2:0]             status_ff, status_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   rsp_type                rsp_ff, rsp_in;
   logic [31:0]            total_dec;
   logic [CNT_W-1:0]       emit_next;
   logic                   emit_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= SEQ_IDLE;
         budget_ff     <= BUDGET_RESET;
         valid_ff      <= '0;
         total_ff      <= '0;
         count_ff      <= '0;
         scan_ff       <= '0;
         rd_live_ff    <= 1'b0;
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         nev_ff        <= '0;
         emit_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         budget_ff     <= budget_in;
         valid_ff      <= valid_in;
         total_ff      <= total_in;
         count_ff      <= count_in;
         scan_ff       <= scan_in;
         rd_live_ff    <= rd_live_in;
         found_ff      <= found_in;
         free_found_ff <= free_found_in;
         nev_ff        <= nev_in;
         emit_ff       <= emit_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff         <= req_in;
      rd_idx_ff      <= rd_idx_in;
      found_idx_ff   <= found_idx_in;
      found_bytes_ff <= found_bytes_in;
      best_age_ff    <= best_age_in;
      free_idx_ff    <= free_idx_in;
      list_ff        <= list_in;
      status_ff      <= status_in;
      rsp_ff         <= rsp_in;
   end

   assign total_dec = total_ff - 32'(found_bytes_ff);
   assign emit_next = emit_ff + 1'b1;
   assign emit_last = emit_next == nev_ff;

   always_comb begin
      state_in       = state_ff;
      req_in         = req_ff;
      budget_in      = csr_we ? csr_wdata : budget_ff;
      valid_in       = valid_ff;
      total_in       = total_ff;
      count_in       = count_ff;
      scan_in        = scan_ff;
      rd_live_in     = 1'b0;
      rd_idx_in      = scan_ff[IDX_W-1:0];
      found_in       = found_ff;
      found_idx_in   = found_idx_ff;
      found_bytes_in = found_bytes_ff;
      best_age_in    = best_age_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      list_in        = list_ff;
      nev_in         = nev_ff;
      emit_in        = emit_ff;
      status_in      = status_ff;
      rsp_strobe_in  = 1'b0;
      rsp_in         = rsp_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = found_idx_ff;
      ram_rd_addr    = scan_ff[IDX_W-1:0];
      case (state_ff)
         SEQ_IDLE: begin
            if (start) begin
               req_in        = req_payload;
               status_in     = STAT_DONE;
               nev_in        = '0;
               emit_in       = '0;
               scan_in       = '0;
               found_in      = 1'b0;
               free_found_in = 1'b0;
               case (req_payload.op)
                  OP_PARK, OP_RECLAIM: begin
                     state_in = SEQ_SCAN;
                  end
                  OP_TRIM: begin
                     if (budget_ff < total_ff) begin
                        state_in = (budget_ff == '0) ? SEQ_SWEEP : SEQ_SCAN;
                     end else begin
                        state_in = SEQ_FINAL;
                     end
                  end
                  OP_CLEAR: begin
                     state_in = SEQ_SWEEP;
                  end
                  default: begin
                     state_in = SEQ_FINAL;
                  end
               endcase
            end
         end
         SEQ_SCAN: begin
            if (scan_ff != SCAN_END) begin
               rd_live_in = 1'b1;
               scan_in    = scan_ff + 1'b1;
            end
            if (rd_live_ff) begin
               if (req_ff.op == OP_TRIM) begin
                  if (valid_ff[rd_idx_ff] && (!found_ff || cmp_res.older)) begin
                     found_in       = 1'b1;
                     found_idx_in   = rd_idx_ff;
                     found_bytes_in = ram_rd_data.bytes;
                     best_age_in    = cmp_res.age;
                  end
               end else begin
                  if (valid_ff[rd_idx_ff] && cmp_res.key_eq && !found_ff) begin
                     found_in       = 1'b1;
                     found_idx_in   = rd_idx_ff;
                     found_bytes_in = ram_rd_data.bytes;
                  end
                  if (!valid_ff[rd_idx_ff] && !free_found_ff) begin
                     free_found_in = 1'b1;
                     free_idx_in   = rd_idx_ff;
                  end
               end
            end
            if (scan_ff == SCAN_END && !rd_live_ff) begin
               state_in = SEQ_DECIDE;
            end
         end
         SEQ_DECIDE: begin
            case (req_ff.op)
               OP_PARK: begin
                  state_in = SEQ_FINAL;
                  if (found_ff) begin
                     ram_wr_en = 1'b1;
                     total_in  = total_dec + 32'(req_ff.entry_bytes);
                  end else if (free_found_ff) begin
                     ram_wr_en             = 1'b1;
                     ram_wr_addr           = free_idx_ff;
                     valid_in[free_idx_ff] = 1'b1;
                     count_in              = count_ff + 1'b1;
                     total_in              = total_ff + 32'(req_ff.entry_bytes);
                  end else begin
                     status_in = STAT_FULL;
                  end
               end
               OP_RECLAIM: begin
                  state_in = SEQ_FINAL;
                  if (found_ff) begin
                     valid_in[found_idx_ff] = 1'b0;
                     count_in               = count_ff - 1'b1;
                     total_in               = total_dec;
                     status_in              = STAT_HIT;
                  end else begin
                     status_in = STAT_MISS;
                  end
               end
               default: begin
                  if (found_ff) begin
                     valid_in[found_idx_ff]        = 1'b0;
                     count_in                      = count_ff - 1'b1;
                     total_in                      = total_dec;
                     list_in[nev_ff[IDX_W-1:0]]    = found_idx_ff;
                     nev_in                        = nev_ff + 1'b1;
                     if (total_dec >= budget_ff) begin
                        state_in = SEQ_SCAN;
                        scan_in  = '0;
                        found_in = 1'b0;
                     end else begin
                        state_in = SEQ_EV_READ;
                     end
                  end else begin
                     state_in = (nev_ff == '0) ? SEQ_FINAL : SEQ_EV_READ;
                  end
               end
            endcase
         end
         SEQ_SWEEP: begin
            if (scan_ff != SCAN_END) begin
               if (valid_ff[scan_ff[IDX_W-1:0]]) begin
                  valid_in[scan_ff[IDX_W-1:0]] = 1'b0;
                  list_in[nev_ff[IDX_W-1:0]]   = scan_ff[IDX_W-1:0];
                  nev_in                       = nev_ff + 1'b1;
               end
               scan_in = scan_ff + 1'b1;
            end else begin
               total_in = '0;
               count_in = '0;
               state_in = (nev_ff == '0) ? SEQ_FINAL : SEQ_EV_READ;
            end
         end
         SEQ_EV_READ: begin
            ram_rd_addr = list_ff[emit_ff[IDX_W-1:0]];
            state_in    = SEQ_EV_SEND;
         end
         SEQ_EV_SEND: begin
            rsp_strobe_in       = 1'b1;
            rsp_in.status       = STAT_EVICT;
            rsp_in.evicted_key  = ram_rd_data.key;
            rsp_in.last         = emit_last;
            rsp_in.cached_count = COUNT_W'(count_ff);
            rsp_in.total_bytes  = total_ff;
            emit_in             = emit_next;
            state_in            = emit_last ? SEQ_IDLE : SEQ_EV_READ;
         end
         SEQ_FINAL: begin
            rsp_strobe_in       = 1'b1;
            rsp_in.status       = status_ff;
            rsp_in.evicted_key  = '0;
            rsp_in.last         = 1'b1;
            rsp_in.cached_count = COUNT_W'(count_ff);
            rsp_in.total_bytes  = total_ff;
            state_in            = SEQ_IDLE;
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   assign ram_wr_data.key   = req_ff.key;
   assign ram_wr_data.frame = req_ff.frame_now;
   assign ram_wr_data.bytes = req_ff.entry_bytes;

   assign cmp_arg.key      = req_ff.key;
   assign cmp_arg.now      = req_ff.frame_now;
   assign cmp_arg.best_age = best_age_ff;

   assign busy        = state_ff != SEQ_IDLE;
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

endmodule

### src/gcbe_checker.sv
// Port-level checker for the glyph cache eviction block, bound to its top level.
// Depends on gcbe_pkg and on the top level's port names.
module gcbe_port_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input gcbe_pkg::rsp_type rsp_payload
);
   import gcbe_pkg::*;

   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("Accepted transaction did not make the block busy.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("Result strobe held for two cycles in a row.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_payload.last |-> busy)
      else $error("Block went idle before the final result of a transaction.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_payload.status != STAT_EVICT |->
         rsp_payload.last && rsp_payload.evicted_key == '0)
      else $error("Non-eviction result is not a single final result with zero key.");

endmodule

bind glyph_cache_budget_eviction gcbe_port_checker u_checker (.*);

### test/gcbe_checker.sv
`timescale 1ns / 100ps
// Checker for the glyph cache budget eviction block: watches every channel,
// keeps its own copy of the cache table and compares each result transaction.
// Depends on gcbe_pkg for the payload types and the operation and status codes.
module gcbe_checker #(
   parameter int TABLE_DEPTH = gcbe_pkg::TABLE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  gcbe_pkg::req_type req_payload,
   input  logic              rsp_strobe,
   input  gcbe_pkg::rsp_type rsp_payload,
   input  logic              csr_we,
   input  logic [31:0]       csr_wdata,
   output int                fail_count,
   output int                outstanding
);
   import gcbe_pkg::*;

   logic [31:0] budget_limit;
   logic        slot_live  [TABLE_DEPTH];
   logic [31:0] slot_tag   [TABLE_DEPTH];
   logic [31:0] slot_stamp [TABLE_DEPTH];
   logic [23:0] slot_size  [TABLE_DEPTH];
   logic [31:0] parked_total;
   rsp_type     cache_answers [$];

   initial begin
      fail_count = 0;
      outstanding = 0;
   end

   task automatic note_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      $display("%0t ns: mismatch on %s, got %h, want %h", $time, what, got, want);
      fail_count++;
   endtask

   function automatic int locate_key(input logic [31:0] key);
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (slot_live[i] && slot_tag[i] == key) return i;
      end
      return -1;
   endfunction

   function automatic logic [31:0] drop_slot(input int i);
      parked_total -= 32'(slot_size[i]);
      slot_live[i] = 1'b0;
      return slot_tag[i];
   endfunction

   function automatic void apply_cache_op(input req_type item);
      int          slot;
      int          victim;
      int          live;
      logic [31:0] oldest_age;
      logic [31:0] age;
      logic [2:0]  status;
      logic [31:0] evicted [$];
      rsp_type     answer;

      status = STAT_DONE;
      case (item.op)
         OP_PARK: begin
            slot = locate_key(item.key);
            if (slot >= 0) begin
               parked_total -= 32'(slot_size[slot]);
            end else begin
               for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
                  if (!slot_live[i]) slot = i;
               end
            end
            if (slot < 0) begin
               status = STAT_FULL;
            end else begin
               slot_live[slot] = 1'b1;
               slot_tag[slot] = item.key;
               slot_stamp[slot] = item.frame_now;
               slot_size[slot] = item.entry_bytes;
               parked_total += 32'(item.entry_bytes);
            end
         end
         OP_RECLAIM: begin
            slot = locate_key(item.key);
            if (slot >= 0) begin
               void'(drop_slot(slot));
               status = STAT_HIT;
            end else begin
               status = STAT_MISS;
            end
         end
         OP_TRIM: begin
            if (budget_limit < parked_total) begin
               if (budget_limit == 0) begin
                  for (int i = 0; i < TABLE_DEPTH; i++) begin
                     if (slot_live[i]) evicted.insert(evicted.size(), drop_slot(i));
                  end
                  parked_total = '0;
               end else begin
                  while (parked_total >= budget_limit) begin
                     victim = -1;
                     oldest_age = '0;
                     for (int i = 0; i < TABLE_DEPTH; i++) begin
                        if (slot_live[i]) begin
                           age = item.frame_now - slot_stamp[i];
                           if (victim < 0 || age > oldest_age) begin
                              victim = i;
                              oldest_age = age;
                           end
                        end
                     end
                     if (victim < 0) break;
                     evicted.insert(evicted.size(), drop_slot(victim));
                  end
               end
            end
         end
         OP_CLEAR: begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (slot_live[i]) evicted.insert(evicted.size(), drop_slot(i));
            end
            parked_total = '0;
         end
         default: ;
      endcase

      live = 0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (slot_live[i]) live++;
      end
      answer.cached_count = live[COUNT_W-1:0];
      answer.total_bytes = parked_total;
      if (evicted.size() == 0) begin
         answer.status = status;
         answer.evicted_key = '0;
         answer.last = 1'b1;
         cache_answers.insert(cache_answers.size(), answer);
      end else begin
         foreach (evicted[k]) begin
            answer.status = STAT_EVICT;
            answer.evicted_key = evicted[k];
            answer.last = (k == evicted.size() - 1);
            cache_answers.insert(cache_answers.size(), answer);
         end
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         for (int i = 0; i < TABLE_DEPTH; i++) slot_live[i] = 1'b0;
         parked_total = '0;
         budget_limit = BUDGET_RESET;
         cache_answers.delete();
      end else begin
         if (rsp_strobe) begin
            if (cache_answers.size() == 0) begin
               note_mismatch("unexpected result transaction, key", rsp_payload.evicted_key,
                             '0);
            end else begin
               want = cache_answers.pop_front();
               if (rsp_payload.status !== want.status)
                  note_mismatch("status", 32'(rsp_payload.status), 32'(want.status));
               if (rsp_payload.evicted_key !== want.evicted_key)
                  note_mismatch("evicted_key", rsp_payload.evicted_key, want.evicted_key);
               if (rsp_payload.last !== want.last)
                  note_mismatch("last", 32'(rsp_payload.last), 32'(want.last));
               if (rsp_payload.cached_count !== want.cached_count)
                  note_mismatch("cached_count", 32'(rsp_payload.cached_count),
                                32'(want.cached_count));
               if (rsp_payload.total_bytes !== want.total_bytes)
                  note_mismatch("total_bytes", rsp_payload.total_bytes, want.total_bytes);
            end
         end
         if (start && !busy) apply_cache_op(req_payload);
         if (csr_we) budget_limit = csr_wdata;
      end
      outstanding = cache_answers.size();
   end

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// Top of the glyph cache budget eviction testbench: clock, reset, stimulus and verdict.
// Depends on gcbe_pkg, the block glyph_cache_budget_eviction and gcbe_checker.
module testbench;
   import gcbe_pkg::*;

   localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;
   localparam int KEY_POOL = 40;
   localparam int PHASES = 6;
   localparam int ITEMS_PER_PHASE = 60;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH;
   localparam logic [2:0] OP_QUERY = 3'd4;
   localparam logic [2:0] OP_RSVD_LO = 3'd5;
   localparam logic [2:0] OP_RSVD_HI = 3'd7;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   req_type     req_payload;
   logic        rsp_strobe;
   rsp_type     rsp_payload;
   logic        csr_we;
   logic [31:0] csr_wdata;
   int          mismatches;
   int          awaited;
   logic [31:0] key_pool [KEY_POOL];
   logic [31:0] frame_clock;
   bit          idling_on;

   glyph_cache_budget_eviction #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_payload(req_payload),
      .rsp_strobe(rsp_strobe),
      .rsp_payload(rsp_payload),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   gcbe_checker #(.TABLE_DEPTH(TABLE_DEPTH)) cache_monitor (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_payload(req_payload),
      .rsp_strobe(rsp_strobe),
      .rsp_payload(rsp_payload),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata),
      .fail_count(mismatches),
      .outstanding(awaited)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic req_type make_req(input logic [2:0] op, input logic [31:0] key,
                                        input logic [23:0] bytes, input logic [31:0] frame);
      req_type item;
      item.op = op;
      item.key = key;
      item.entry_bytes = bytes;
      item.frame_now = frame;
      return item;
   endfunction

   function automatic req_type random_item();
      req_type item;
      int      pick;
      frame_clock += 32'($urandom_range(3));
      pick = $urandom_range(99);
      if (pick < 45) item.op = OP_PARK;
      else if (pick < 65) item.op = OP_RECLAIM;
      else if (pick < 80) item.op = OP_TRIM;
      else if (pick < 83) item.op = OP_CLEAR;
      else if (pick < 95) item.op = OP_QUERY;
      else item.op = 3'($urandom_range(OP_RSVD_HI, OP_RSVD_LO));
      item.key = ($urandom_range(9) == 0) ? $urandom : key_pool[$urandom_range(KEY_POOL - 1)];
      pick = $urandom_range(99);
      if (pick < 75) item.entry_bytes = 24'($urandom_range(65535));
      else if (pick < 95) item.entry_bytes = 24'($urandom);
      else item.entry_bytes = pick[0] ? '1 : '0;
      pick = $urandom_range(99);
      if (pick < 3) frame_clock = $urandom;
      if (pick >= 3 && pick < 13) item.frame_now = frame_clock - 32'($urandom_range(40));
      else item.frame_now = frame_clock;
      return item;
   endfunction

   task automatic issue(input req_type item);
      while (idling_on && $urandom_range(99) < 18) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic set_budget(input logic [31:0] value);
      start <= 1'b0;
      @(negedge clock);
      while (awaited != 0 || busy) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_strobe) quiet = 0;
         else quiet++;
      end
      $display("FAIL glyph_cache_budget_eviction");
      $finish;
   end

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_payload = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      idling_on = 1'b1;
      frame_clock = 32'hFFFF_FF00;
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom;
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      issue(make_req(OP_QUERY, '0, '0, '0));
      issue(make_req(OP_RECLAIM, '0, '0, '0));
      issue(make_req(OP_CLEAR, '0, '0, '0));
      issue(make_req(OP_TRIM, '0, '0, '0));
      issue(make_req(OP_PARK, '0, '0, '0));
      issue(make_req(OP_PARK, '1, '1, '1));
      issue(make_req(OP_PARK, '0, 24'd1234, 32'd7));
      issue(make_req(OP_RECLAIM, '1, '0, '0));
      issue(make_req(OP_RSVD_LO, '1, '1, '1));
      issue(make_req(OP_RSVD_HI, '0, '0, '0));
      issue(make_req(OP_PARK, 32'h11, 24'd200000, 32'd100));
      issue(make_req(OP_PARK, 32'h22, 24'd200000, 32'd100));
      issue(make_req(OP_PARK, 32'h33, 24'd200000, 32'hFFFF_FFF0));
      issue(make_req(OP_TRIM, '0, '0, 32'd120));
      issue(make_req(OP_PARK, 32'h44, 24'd300000, 32'd100));
      issue(make_req(OP_TRIM, '0, '0, 32'd120));
      issue(make_req(OP_TRIM, '0, '0, 32'd120));
      issue(make_req(OP_CLEAR, '0, '0, 32'd120));
      set_budget('0);
      issue(make_req(OP_PARK, 32'h55, '0, 32'd200));
      issue(make_req(OP_TRIM, '0, '0, 32'd210));
      issue(make_req(OP_PARK, 32'h66, 24'd9, 32'd201));
      issue(make_req(OP_PARK, 32'h77, '1, 32'd150));
      issue(make_req(OP_TRIM, '0, '0, 32'd300));

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: set_budget('1);
            1: set_budget(32'd1);
            2: set_budget($urandom_range(32'h0010_0000, 32'h0000_1000));
            3: set_budget(BUDGET_RESET);
            4: set_budget('0);
            default: set_budget($urandom_range(32'h01FF_FFFF, 1));
         endcase
         idling_on = (phase != 3);
         if (phase == 0) begin
            repeat (TABLE_DEPTH + 4)
               issue(make_req(OP_PARK, $urandom, 24'($urandom_range(65535)), frame_clock));
         end
         repeat (ITEMS_PER_PHASE) issue(random_item());
      end

      start <= 1'b0;
      @(negedge clock);
      while (awaited != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0 && awaited == 0)
         $display("PASS glyph_cache_budget_eviction");
      else
         $display("FAIL glyph_cache_budget_eviction");
      $finish;
   end

endmodule
